@@ hw/rtl/bsdt_pkg.sv @@
// ----------------------------------------------------------------------------
// bsdt_pkg
// Shared types and constants of the bulk surface drag tendency pipeline.
// ----------------------------------------------------------------------------
package bsdt_pkg;

    // default number of fraction bits of the fixed-point fields
    localparam int FRAC_BITS_DEF = 16;

    // saturation ceiling of the drag magnitude chain, 2^62 - 1
    localparam logic [61:0] CAP       = 62'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [30:0] VEL_MAX   = 31'h7FFF_FFFF;
    localparam logic [20:0] COEFF_MAX = 21'd1048576;
    localparam logic [16:0] MASK_ONE  = 17'd65536;
    localparam logic [17:0] MASK_TWO  = 18'd131072;

    // configuration reset values
    localparam logic [7:0]  DRAG_LEVELS_RST = 8'd1;
    localparam logic [20:0] SEA_COEFF_RST   = 21'd1049;
    localparam logic [20:0] LAND_COEFF_RST  = 21'd10486;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_DRAG_LEVELS = 2'd0,
        REG_SEA_COEFF   = 2'd1,
        REG_LAND_COEFF  = 2'd2
    } t_reg_idx;

    // sideband carried through the velocity dividers
    typedef struct packed {
        logic        pass;
        logic        fault;
        logic        mode;
        logic        sx;
        logic        sy;
        logic [31:0] rhs;
        logic [7:0]  w;
        logic [30:0] rho_f;
        logic [31:0] dz;
        logic [20:0] cd;
    } t_side1;

    // sideband carried through the square root and the product chain
    typedef struct packed {
        logic        pass;
        logic        fault;
        logic        vneg;
        logic [31:0] rhs;
        logic [7:0]  w;
        logic [30:0] rho_f;
        logic [31:0] dz;
        logic [20:0] cd;
        logic [30:0] velm;
    } t_side2;

    // sideband carried through the level and height dividers
    typedef struct packed {
        logic        pass;
        logic        fault;
        logic        vneg;
        logic [31:0] rhs;
        logic [31:0] dz;
    } t_side3;

endpackage

@@ hw/rtl/bsdt_div.sv @@
// ----------------------------------------------------------------------------
// bsdt_div
// Pipelined restoring divider, one quotient bit per stage, with parallel
// lanes that share valid and sideband.
// ----------------------------------------------------------------------------
module bsdt_div #(
    parameter int NW    = 48,
    parameter int DW    = 31,
    parameter int LANES = 1,
    parameter int TAG_W = 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [LANES-1:0][NW-1:0]       i_num,
    input  logic [LANES-1:0][DW-1:0]       i_den,
    input  logic [TAG_W-1:0]               i_tag,
    output logic                           o_valid,
    output logic [LANES-1:0][NW-1:0]       o_quo,
    output logic [TAG_W-1:0]               o_tag
);

    logic             r_v   [NW];
    logic [TAG_W-1:0] r_tag [NW];
    logic [DW-1:0]    r_rem [NW][LANES];
    logic [NW-1:0]    r_num [NW][LANES];
    logic [DW-1:0]    r_den [NW][LANES];

    for (genvar s = 0; s < NW; s++) begin : g_stage
        logic             v_in;
        logic [TAG_W-1:0] tag_in;
        logic [DW-1:0]    rem_in [LANES];
        logic [NW-1:0]    num_in [LANES];
        logic [DW-1:0]    den_in [LANES];

        // stage inputs: ports for the first stage, previous stage otherwise
        if (s == 0) begin : g_head
            assign v_in   = i_valid;
            assign tag_in = i_tag;
            for (genvar l = 0; l < LANES; l++) begin : g_in
                assign rem_in[l] = '0;
                assign num_in[l] = i_num[l];
                assign den_in[l] = i_den[l];
            end
        end else begin : g_body
            assign v_in   = r_v[s-1];
            assign tag_in = r_tag[s-1];
            for (genvar l = 0; l < LANES; l++) begin : g_in
                assign rem_in[l] = r_rem[s-1][l];
                assign num_in[l] = r_num[s-1][l];
                assign den_in[l] = r_den[s-1][l];
            end
        end

        // one trial subtraction per lane, quotient bit shifts in at the bottom
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [DW:0] trial;
            logic        take;
            assign trial = {rem_in[l], num_in[l][NW-1]};
            assign take  = (trial >= {1'b0, den_in[l]});
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s][l] <= take ? DW'(trial - {1'b0, den_in[l]}) : trial[DW-1:0];
                    r_num[s][l] <= {num_in[l][NW-2:0], take};
                    r_den[s][l] <= den_in[l];
                end
            end
        end

        // valid travels with the data
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[s] <= tag_in;
            end
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_tag   = r_tag[NW-1];
    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign o_quo[l] = r_num[NW-1][l];
    end

endmodule

@@ hw/rtl/bsdt_sqrt.sv @@
// ----------------------------------------------------------------------------
// bsdt_sqrt
// Pipelined floor integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module bsdt_sqrt #(
    parameter int XW    = 64,
    parameter int TAG_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [XW-1:0]     i_x,
    input  logic [TAG_W-1:0]  i_tag,
    output logic              o_valid,
    output logic [XW/2-1:0]   o_root,
    output logic [TAG_W-1:0]  o_tag
);

    localparam int RW = XW / 2;

    logic             r_v    [RW];
    logic [TAG_W-1:0] r_tag  [RW];
    logic [RW+1:0]    r_rem  [RW];
    logic [RW-1:0]    r_root [RW];
    logic [XW-1:0]    r_x    [RW];

    for (genvar s = 0; s < RW; s++) begin : g_stage
        logic             v_in;
        logic [TAG_W-1:0] tag_in;
        logic [RW+1:0]    rem_in;
        logic [RW-1:0]    root_in;
        logic [XW-1:0]    x_in;
        logic [RW+3:0]    trial;
        logic [RW+3:0]    cmp;
        logic             take;

        // stage inputs
        if (s == 0) begin : g_head
            assign v_in    = i_valid;
            assign tag_in  = i_tag;
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = i_x;
        end else begin : g_body
            assign v_in    = r_v[s-1];
            assign tag_in  = r_tag[s-1];
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
            assign x_in    = r_x[s-1];
        end

        // bring down the next bit pair and try root*4 + 1
        assign trial = {rem_in, x_in[XW-1:XW-2]};
        assign cmp   = {2'b00, root_in, 2'b01};
        assign take  = (trial >= cmp);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= take ? (RW+2)'(trial - cmp) : trial[RW+1:0];
                r_root[s] <= {root_in[RW-2:0], take};
                r_x[s]    <= {x_in[XW-3:0], 2'b00};
                r_tag[s]  <= tag_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= v_in;
            end
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_tag   = r_tag[RW-1];

endmodule

@@ hw/rtl/bulk_surface_drag_tendency.sv @@
// ----------------------------------------------------------------------------
// bulk_surface_drag_tendency
// Bulk aerodynamic surface drag applied to one face point of a momentum
// tendency per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_ready carries one face point per beat;
//   output channel o_out_valid / i_out_ready returns the updated tendency and
//   a fault flag, one beat per input beat, in order.
//   Configuration (drag levels, sea and land coefficients) is written through
//   i_cfg_we / i_cfg_idx / i_cfg_data while the pipeline is empty.
//   Throughput: one beat per cycle while the output is not stalled. The
//   latency is set by the bit-per-stage dividers (two momentum divides,
//   the level-weight divide and the height divide) and the bit-per-stage
//   square root.
//   Reset empties the pipeline and loads the default configuration.
//   When the receiver stalls, the whole pipeline holds and o_in_ready drops;
//   the waiting result stays on the output ports unchanged.
// ----------------------------------------------------------------------------
module bulk_surface_drag_tendency #(
    parameter int FRAC_BITS = bsdt_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [20:0]        i_cfg_data,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_mode,
    input  logic [7:0]         i_level,
    input  logic signed [31:0] i_rhs_in,
    input  logic signed [31:0] i_mom_x,
    input  logic signed [31:0] i_mom_y,
    input  logic [30:0]        i_rho_here,
    input  logic [30:0]        i_rho_west,
    input  logic [30:0]        i_rho_south,
    input  logic [16:0]        i_mask_here,
    input  logic [16:0]        i_mask_neighbor,
    input  logic signed [31:0] i_z_bottom,
    input  logic signed [31:0] i_z_top,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_rhs_out,
    output logic               o_fault
);

    localparam int VNW = 32 + FRAC_BITS;
    localparam int ZNW = 62 + FRAC_BITS;
    localparam int S1W = $bits(bsdt_pkg::t_side1);
    localparam int S2W = $bits(bsdt_pkg::t_side2);
    localparam int S3W = $bits(bsdt_pkg::t_side3);

    logic en;

    // configuration registers
    logic [7:0]  r_drag_levels;
    logic [20:0] r_sea_coeff;
    logic [20:0] r_land_coeff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drag_levels <= bsdt_pkg::DRAG_LEVELS_RST;
            r_sea_coeff   <= bsdt_pkg::SEA_COEFF_RST;
            r_land_coeff  <= bsdt_pkg::LAND_COEFF_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bsdt_pkg::REG_DRAG_LEVELS: r_drag_levels <= i_cfg_data[7:0];
                bsdt_pkg::REG_SEA_COEFF:   r_sea_coeff   <= i_cfg_data;
                bsdt_pkg::REG_LAND_COEFF:  r_land_coeff  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [7:0]  nl;
    logic [20:0] sea_sat;
    logic [20:0] land_sat;
    assign nl       = (r_drag_levels == '0) ? 8'd1 : r_drag_levels;
    assign sea_sat  = (r_sea_coeff > bsdt_pkg::COEFF_MAX) ? bsdt_pkg::COEFF_MAX : r_sea_coeff;
    assign land_sat = (r_land_coeff > bsdt_pkg::COEFF_MAX) ? bsdt_pkg::COEFF_MAX : r_land_coeff;

    // global advance: the pipeline moves unless a result waits on a stalled output
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // ---------------- stage 1: face densities, checks, magnitudes ----------------
    bsdt_pkg::t_side1 n_s1_side;
    logic [17:0]      n_s1_m;
    logic             n_s1_lvl0;
    logic [31:0]      n_s1_mx;
    logic [31:0]      n_s1_my;
    logic [30:0]      n_s1_rho_u;
    logic [30:0]      n_s1_rho_v;

    always_comb begin
        logic               bypass;
        logic               bad;
        logic signed [32:0] dz;
        logic [16:0]        mh;
        logic [16:0]        mn;
        bypass     = (i_level > nl);
        n_s1_rho_u = 31'(({1'b0, i_rho_here} + {1'b0, i_rho_west}) >> 1);
        n_s1_rho_v = 31'(({1'b0, i_rho_here} + {1'b0, i_rho_south}) >> 1);
        dz         = {i_z_top[31], i_z_top} - {i_z_bottom[31], i_z_bottom};
        bad        = (n_s1_rho_u == '0) || (n_s1_rho_v == '0) || dz[32] || (dz == '0);
        mh         = (i_mask_here > bsdt_pkg::MASK_ONE) ? bsdt_pkg::MASK_ONE : i_mask_here;
        mn         = (i_mask_neighbor > bsdt_pkg::MASK_ONE) ? bsdt_pkg::MASK_ONE
                                                            : i_mask_neighbor;
        n_s1_m     = {1'b0, mh} + {1'b0, mn};
        n_s1_lvl0  = (i_level == '0);
        n_s1_mx    = i_mom_x[31] ? 32'(-i_mom_x) : 32'(i_mom_x);
        n_s1_my    = i_mom_y[31] ? 32'(-i_mom_y) : 32'(i_mom_y);

        n_s1_side.pass  = bypass || bad;
        n_s1_side.fault = !bypass && bad;
        n_s1_side.mode  = i_mode;
        n_s1_side.sx    = i_mom_x[31];
        n_s1_side.sy    = i_mom_y[31];
        n_s1_side.rhs   = i_rhs_in;
        n_s1_side.w     = nl - i_level;
        n_s1_side.rho_f = i_mode ? n_s1_rho_v : n_s1_rho_u;
        n_s1_side.dz    = dz[31:0];
        n_s1_side.cd    = '0;
    end

    logic             r_s1_v;
    bsdt_pkg::t_side1 r_s1_side;
    logic [17:0]      r_s1_m;
    logic             r_s1_lvl0;
    logic [31:0]      r_s1_mx;
    logic [31:0]      r_s1_my;
    logic [30:0]      r_s1_rho_u;
    logic [30:0]      r_s1_rho_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_side  <= n_s1_side;
            r_s1_m     <= n_s1_m;
            r_s1_lvl0  <= n_s1_lvl0;
            r_s1_mx    <= n_s1_mx;
            r_s1_my    <= n_s1_my;
            r_s1_rho_u <= n_s1_rho_u;
            r_s1_rho_v <= n_s1_rho_v;
        end
    end

    // ---------------- stage 2: drag coefficient products ----------------
    logic             r_s2_v;
    bsdt_pkg::t_side1 r_s2_side;
    logic [38:0]      r_s2_pland;
    logic [38:0]      r_s2_psea;
    logic [31:0]      r_s2_mx;
    logic [31:0]      r_s2_my;
    logic [30:0]      r_s2_rho_u;
    logic [30:0]      r_s2_rho_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_side  <= r_s1_side;
            r_s2_pland <= 39'(land_sat) * 39'(r_s1_m);
            r_s2_psea  <= r_s1_lvl0 ? 39'(sea_sat) * 39'(bsdt_pkg::MASK_TWO - r_s1_m) : '0;
            r_s2_mx    <= r_s1_mx;
            r_s2_my    <= r_s1_my;
            r_s2_rho_u <= r_s1_rho_u;
            r_s2_rho_v <= r_s1_rho_v;
        end
    end

    // ---------------- velocity dividers ----------------
    bsdt_pkg::t_side1        vd_side_in;
    bsdt_pkg::t_side1        vd_side_out;
    logic [S1W-1:0]          vd_tag_out;
    logic [1:0][VNW-1:0]     vd_num;
    logic [1:0][30:0]        vd_den;
    logic [1:0][VNW-1:0]     vd_quo;
    logic                    vd_valid;

    always_comb begin
        vd_side_in    = r_s2_side;
        vd_side_in.cd = 21'(({1'b0, r_s2_pland} + {1'b0, r_s2_psea}) >> 17);
    end

    assign vd_num[0] = {r_s2_mx, {FRAC_BITS{1'b0}}};
    assign vd_num[1] = {r_s2_my, {FRAC_BITS{1'b0}}};
    assign vd_den[0] = r_s2_rho_u;
    assign vd_den[1] = r_s2_rho_v;

    bsdt_div #(
        .NW    (VNW),
        .DW    (31),
        .LANES (2),
        .TAG_W (S1W)
    ) u_vel_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s2_v),
        .i_num   (vd_num),
        .i_den   (vd_den),
        .i_tag   (vd_side_in),
        .o_valid (vd_valid),
        .o_quo   (vd_quo),
        .o_tag   (vd_tag_out)
    );

    assign vd_side_out = bsdt_pkg::t_side1'(vd_tag_out);

    // ---------------- stage 4: velocity saturation ----------------
    logic [30:0]      n_s4_u;
    logic [30:0]      n_s4_v;
    bsdt_pkg::t_side2 n_s4_side;

    always_comb begin
        n_s4_u = (|vd_quo[0][VNW-1:31]) ? bsdt_pkg::VEL_MAX : vd_quo[0][30:0];
        n_s4_v = (|vd_quo[1][VNW-1:31]) ? bsdt_pkg::VEL_MAX : vd_quo[1][30:0];
        n_s4_side.pass  = vd_side_out.pass;
        n_s4_side.fault = vd_side_out.fault;
        n_s4_side.vneg  = vd_side_out.mode ? vd_side_out.sy : vd_side_out.sx;
        n_s4_side.rhs   = vd_side_out.rhs;
        n_s4_side.w     = vd_side_out.w;
        n_s4_side.rho_f = vd_side_out.rho_f;
        n_s4_side.dz    = vd_side_out.dz;
        n_s4_side.cd    = vd_side_out.cd;
        n_s4_side.velm  = vd_side_out.mode ? n_s4_v : n_s4_u;
    end

    logic             r_s4_v;
    bsdt_pkg::t_side2 r_s4_side;
    logic [30:0]      r_s4_u;
    logic [30:0]      r_s4_vel_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else if (en) begin
            r_s4_v <= vd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_side  <= n_s4_side;
            r_s4_u     <= n_s4_u;
            r_s4_vel_y <= n_s4_v;
        end
    end

    // ---------------- stage 5: squares ----------------
    logic             r_s5_v;
    bsdt_pkg::t_side2 r_s5_side;
    logic [61:0]      r_s5_uu;
    logic [61:0]      r_s5_vv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
        end else if (en) begin
            r_s5_v <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5_side <= r_s4_side;
            r_s5_uu   <= 62'(r_s4_u) * 62'(r_s4_u);
            r_s5_vv   <= 62'(r_s4_vel_y) * 62'(r_s4_vel_y);
        end
    end

    // ---------------- speed ----------------
    logic [63:0]      sq_x;
    logic [31:0]      sq_root;
    logic [S2W-1:0]   sq_tag_out;
    logic             sq_valid;
    bsdt_pkg::t_side2 sq_side;

    assign sq_x = {1'b0, 63'({1'b0, r_s5_uu} + {1'b0, r_s5_vv})};

    bsdt_sqrt #(
        .XW    (64),
        .TAG_W (S2W)
    ) u_speed (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s5_v),
        .i_x     (sq_x),
        .i_tag   (r_s5_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_tag   (sq_tag_out)
    );

    assign sq_side = bsdt_pkg::t_side2'(sq_tag_out);

    // ---------------- stages 6 to 10: drag magnitude products ----------------
    logic             r_s6_v, r_s7_v, r_s8_v, r_s9_v, r_s10_v;
    bsdt_pkg::t_side2 r_s6_side, r_s7_side, r_s8_side, r_s9_side, r_s10_side;
    logic [52:0]      r_s6_p1;
    logic [63:0]      r_s7_p2;
    logic [61:0]      r_s8_ph;
    logic [61:0]      r_s8_pl;
    logic [61:0]      r_s9_mag3;
    logic [61:0]      r_s10_mag4;

    logic [61:0]      mag2;
    logic [92:0]      full3;
    logic [69:0]      p4;

    // saturate the rho product, split it for the velocity product
    assign mag2  = (r_s7_p2 > {2'b00, bsdt_pkg::CAP}) ? bsdt_pkg::CAP
                                                       : 62'(r_s7_p2 >> FRAC_BITS);
    assign full3 = {r_s8_ph, 31'd0} + {31'd0, r_s8_pl};
    assign p4    = 70'(r_s9_mag3) * 70'(r_s9_side.w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_v  <= 1'b0;
            r_s7_v  <= 1'b0;
            r_s8_v  <= 1'b0;
            r_s9_v  <= 1'b0;
            r_s10_v <= 1'b0;
        end else if (en) begin
            r_s6_v  <= sq_valid;
            r_s7_v  <= r_s6_v;
            r_s8_v  <= r_s7_v;
            r_s9_v  <= r_s8_v;
            r_s10_v <= r_s9_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s6_side  <= sq_side;
            r_s6_p1    <= 53'(sq_side.cd) * 53'(sq_root);
            r_s7_side  <= r_s6_side;
            r_s7_p2    <= 64'(r_s6_p1[52:20]) * 64'(r_s6_side.rho_f);
            r_s8_side  <= r_s7_side;
            r_s8_ph    <= 62'(mag2[61:31]) * 62'(r_s7_side.velm);
            r_s8_pl    <= 62'(mag2[30:0]) * 62'(r_s7_side.velm);
            r_s9_side  <= r_s8_side;
            r_s9_mag3  <= (full3 > {31'd0, bsdt_pkg::CAP}) ? bsdt_pkg::CAP
                                                            : 62'(full3 >> FRAC_BITS);
            r_s10_side <= r_s9_side;
            r_s10_mag4 <= (p4 > {8'd0, bsdt_pkg::CAP}) ? bsdt_pkg::CAP : p4[61:0];
        end
    end

    // ---------------- level weight divider ----------------
    bsdt_pkg::t_side3 ld_side_in;
    logic [S3W-1:0]   ld_tag_out;
    logic [0:0][61:0] ld_quo;
    logic             ld_valid;

    assign ld_side_in.pass  = r_s10_side.pass;
    assign ld_side_in.fault = r_s10_side.fault;
    assign ld_side_in.vneg  = r_s10_side.vneg;
    assign ld_side_in.rhs   = r_s10_side.rhs;
    assign ld_side_in.dz    = r_s10_side.dz;

    bsdt_div #(
        .NW    (62),
        .DW    (8),
        .LANES (1),
        .TAG_W (S3W)
    ) u_lvl_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s10_v),
        .i_num   (r_s10_mag4),
        .i_den   (nl),
        .i_tag   (ld_side_in),
        .o_valid (ld_valid),
        .o_quo   (ld_quo),
        .o_tag   (ld_tag_out)
    );

    // ---------------- height divider, Q result ----------------
    bsdt_pkg::t_side3  ld_side;
    logic [0:0][ZNW-1:0] zd_num;
    logic [0:0][31:0]  zd_den;
    logic [0:0][ZNW-1:0] zd_quo;
    logic [S3W-1:0]    zd_tag_out;
    logic              zd_valid;
    bsdt_pkg::t_side3  zd_side;

    assign ld_side   = bsdt_pkg::t_side3'(ld_tag_out);
    assign zd_num[0] = {ld_quo[0], {FRAC_BITS{1'b0}}};
    assign zd_den[0] = ld_side.dz;

    bsdt_div #(
        .NW    (ZNW),
        .DW    (32),
        .LANES (1),
        .TAG_W (S3W)
    ) u_dz_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ld_valid),
        .i_num   (zd_num),
        .i_den   (zd_den),
        .i_tag   (ld_tag_out),
        .o_valid (zd_valid),
        .o_quo   (zd_quo),
        .o_tag   (zd_tag_out)
    );

    assign zd_side = bsdt_pkg::t_side3'(zd_tag_out);

    // ---------------- output register: apply drag with saturation ----------------
    logic [31:0] n_rhs;

    always_comb begin
        logic [61:0]        drag;
        logic signed [63:0] rhs_x;
        logic signed [63:0] sum;
        drag  = (zd_quo[0] > ZNW'(bsdt_pkg::CAP)) ? bsdt_pkg::CAP : zd_quo[0][61:0];
        rhs_x = 64'(signed'(zd_side.rhs));
        sum   = zd_side.vneg ? rhs_x + signed'({2'b00, drag})
                             : rhs_x - signed'({2'b00, drag});
        if (zd_side.pass) begin
            n_rhs = zd_side.rhs;
        end else if (sum > 64'sd2147483647) begin
            n_rhs = 32'h7FFF_FFFF;
        end else if (sum < -64'sd2147483648) begin
            n_rhs = 32'h8000_0000;
        end else begin
            n_rhs = sum[31:0];
        end
    end

    logic        r_out_valid;
    logic [31:0] r_out_rhs;
    logic        r_out_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= zd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_rhs   <= n_rhs;
            r_out_fault <= zd_side.fault;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rhs_out   = r_out_rhs;
    assign o_fault     = r_out_fault;

endmodule

@@ hw/rtl/bsdt_check.sv @@
// ----------------------------------------------------------------------------
// bsdt_check
// Port-level checks of the drag pipeline handshake, bound to the top level.
// ----------------------------------------------------------------------------
module bsdt_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_rhs_out,
    input logic        o_fault
);

    // a result waiting on a stalled receiver holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_rhs_out) && $stable(o_fault))
        else $error("stalled output changed");

    // an empty output slot never blocks the input side
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

    // a stalled output freezes the pipeline
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken during output stall");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind bulk_surface_drag_tendency bsdt_check u_bsdt_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_rhs_out   (o_rhs_out),
    .o_fault     (o_fault)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams face points through bulk_surface_drag_tendency under several drag
// settings and random handshake gaps, and checks each output beat against a
// fixed-point drag predictor kept in this file or a listed directed result.
// ----------------------------------------------------------------------------
module testbench;

    localparam int FB = bsdt_pkg::FRAC_BITS_DEF;
    localparam longint unsigned DRAG_CAP = 64'h3FFF_FFFF_FFFF_FFFF;

    typedef struct {
        bit              mode;
        bit [7:0]        level;
        bit [31:0]       rhs;
        bit [31:0]       mom_x;
        bit [31:0]       mom_y;
        bit [30:0]       rho_h;
        bit [30:0]       rho_w;
        bit [30:0]       rho_s;
        bit [16:0]       mask_h;
        bit [16:0]       mask_n;
        bit [31:0]       z_bot;
        bit [31:0]       z_top;
    } t_point;

    typedef struct {
        bit [31:0] rhs;
        bit        fault;
    } t_tend;

    typedef struct {
        t_point p;
        bit     typed;
        t_tend  res;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [20:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_mode;
    logic [7:0]         i_level;
    logic signed [31:0] i_rhs_in;
    logic signed [31:0] i_mom_x;
    logic signed [31:0] i_mom_y;
    logic [30:0]        i_rho_here;
    logic [30:0]        i_rho_west;
    logic [30:0]        i_rho_south;
    logic [16:0]        i_mask_here;
    logic [16:0]        i_mask_neighbor;
    logic signed [31:0] i_z_bottom;
    logic signed [31:0] i_z_top;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_rhs_out;
    logic               o_fault;

    // drag settings as the block holds them
    bit [7:0]  levels_reg;
    bit [20:0] sea_reg;
    bit [20:0] land_reg;

    t_tend tend_q[$];
    int    err_count;
    int    tx_idle_pct;
    int    rx_idle_pct;

    bulk_surface_drag_tendency uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_level         (i_level),
        .i_rhs_in        (i_rhs_in),
        .i_mom_x         (i_mom_x),
        .i_mom_y         (i_mom_y),
        .i_rho_here      (i_rho_here),
        .i_rho_west      (i_rho_west),
        .i_rho_south     (i_rho_south),
        .i_mask_here     (i_mask_here),
        .i_mask_neighbor (i_mask_neighbor),
        .i_z_bottom      (i_z_bottom),
        .i_z_top         (i_z_top),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_rhs_out       (o_rhs_out),
        .o_fault         (o_fault)
    );

    // clock, 10 ns period
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // face velocity, truncated toward zero and clipped
    function automatic longint face_vel(longint mom, longint unsigned rho);
        longint unsigned mag;
        longint unsigned q;
        mag = (mom < 0) ? longint'(-mom) : longint'(mom);
        q = (mag << FB) / rho;
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        return (mom < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // saturating product then shift
    function automatic longint unsigned sat_mul(longint unsigned x, longint unsigned y,
                                                int sh);
        if (y != 0 && x > DRAG_CAP / y) return DRAG_CAP;
        return (x * y) >> sh;
    endfunction

    // updated tendency for one face point under the current settings
    function automatic t_tend drag_tendency(t_point p);
        t_tend           t;
        longint unsigned nl, sea, land, rho_u, rho_v, rho_f, m, cd, spd, mag, q, r;
        longint unsigned mh, mn, dzu;
        longint          u, v, vel, dz, res, rhs;
        rhs = longint'($signed(p.rhs));
        t.rhs = p.rhs;
        t.fault = 1'b0;
        nl = (levels_reg == 0) ? 1 : levels_reg;
        sea = (sea_reg > bsdt_pkg::COEFF_MAX) ? bsdt_pkg::COEFF_MAX : sea_reg;
        land = (land_reg > bsdt_pkg::COEFF_MAX) ? bsdt_pkg::COEFF_MAX : land_reg;
        if (p.level > nl) return t;
        rho_u = (longint'(p.rho_h) + p.rho_w) >> 1;
        rho_v = (longint'(p.rho_h) + p.rho_s) >> 1;
        dz = longint'($signed(p.z_top)) - longint'($signed(p.z_bot));
        if (rho_u == 0 || rho_v == 0 || dz <= 0) begin
            t.fault = 1'b1;
            return t;
        end
        // land/sea blend of the drag coefficient
        mh = (p.mask_h > bsdt_pkg::MASK_ONE) ? bsdt_pkg::MASK_ONE : p.mask_h;
        mn = (p.mask_n > bsdt_pkg::MASK_ONE) ? bsdt_pkg::MASK_ONE : p.mask_n;
        m = mh + mn;
        cd = land * m;
        if (p.level == 0) cd += sea * (bsdt_pkg::MASK_TWO - m);
        cd >>= 17;
        u = face_vel(longint'($signed(p.mom_x)), rho_u);
        v = face_vel(longint'($signed(p.mom_y)), rho_v);
        spd = floor_sqrt(longint'(u * u) + longint'(v * v));
        vel = p.mode ? v : u;
        rho_f = p.mode ? rho_v : rho_u;
        // magnitude chain
        mag = sat_mul(cd, spd, 20);
        mag = sat_mul(mag, rho_f, FB);
        mag = sat_mul(mag, (vel < 0) ? -vel : vel, FB);
        mag = sat_mul(mag, nl - p.level, 0) / nl;
        dzu = dz;
        q = mag / dzu;
        r = mag % dzu;
        if (q > (DRAG_CAP >> FB)) mag = DRAG_CAP;
        else mag = (q << FB) + ((r << FB) / dzu);
        if (mag > DRAG_CAP) mag = DRAG_CAP;
        res = (vel < 0) ? rhs + longint'(mag) : rhs - longint'(mag);
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;
        t.rhs = res[31:0];
        return t;
    endfunction

    task automatic write_reg(bsdt_pkg::t_reg_idx idx, bit [20:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        case (idx)
            bsdt_pkg::REG_DRAG_LEVELS: levels_reg = data[7:0];
            bsdt_pkg::REG_SEA_COEFF:   sea_reg = data;
            default:                   land_reg = data;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // present one beat, hold it until accepted; entered and left at a falling edge
    task automatic send_point(t_point p, bit typed, t_tend res);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_mode = p.mode;
        i_level = p.level;
        i_rhs_in = p.rhs;
        i_mom_x = p.mom_x;
        i_mom_y = p.mom_y;
        i_rho_here = p.rho_h;
        i_rho_west = p.rho_w;
        i_rho_south = p.rho_s;
        i_mask_here = p.mask_h;
        i_mask_neighbor = p.mask_n;
        i_z_bottom = p.z_bot;
        i_z_top = p.z_top;
        do @(posedge i_clk); while (!o_in_ready);
        tend_q.push_back(typed ? res : drag_tendency(p));
        @(negedge i_clk);
    endtask

    function automatic bit [31:0] rand_mom();
        bit [31:0] v;
        v = $urandom >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic bit [30:0] rand_rho();
        case ($urandom_range(0, 9))
            0:       return 31'd0;
            1:       return 31'($urandom_range(1, 4));
            default: return 31'($urandom >> $urandom_range(1, 31));
        endcase
    endfunction

    function automatic bit [16:0] rand_mask();
        case ($urandom_range(0, 5))
            0:       return 17'($urandom_range(0, 131071));
            1:       return bsdt_pkg::MASK_ONE;
            2:       return 17'd0;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic t_point rand_point();
        t_point p;
        int     nl;
        nl = (levels_reg == 0) ? 1 : levels_reg;
        p.mode = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0:       p.level = 8'($urandom_range(0, 255));
            1, 2, 3: p.level = 8'd0;
            default: p.level = 8'($urandom_range(0, nl));
        endcase
        if ($urandom_range(0, 9) == 0) begin
            p.rhs = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        end else begin
            p.rhs = $urandom;
        end
        p.mom_x = rand_mom();
        p.mom_y = rand_mom();
        p.rho_h = rand_rho();
        p.rho_w = rand_rho();
        p.rho_s = rand_rho();
        p.mask_h = rand_mask();
        p.mask_n = rand_mask();
        if ($urandom_range(0, 9) == 0) begin
            p.z_bot = $urandom;
            p.z_top = $urandom;
        end else begin
            p.z_bot = $signed($urandom) >>> $urandom_range(0, 16);
            p.z_top = p.z_bot + ($urandom >> $urandom_range(2, 31));
        end
        return p;
    endfunction

    // directed rows under the reset settings (one drag level)
    t_row dir_rows[] = '{
        // above drag levels: tendency passes
        '{'{0, 2, 32'h7FFF_FFFF, 5, 5, 65536, 65536, 65536, 0, 0, 0, 65536},
          1, '{32'h7FFF_FFFF, 0}},
        '{'{1, 255, 32'h8000_0000, 5, 5, 65536, 65536, 65536, 0, 0, 0, 65536},
          1, '{32'h8000_0000, 0}},
        // zero densities
        '{'{0, 0, 1234, 5, 5, 0, 0, 0, 0, 0, 0, 65536}, 1, '{1234, 1}},
        '{'{0, 1, 77, 5, 5, 1, 0, 9, 0, 0, 0, 65536}, 1, '{77, 1}},
        '{'{1, 0, 55, 5, 5, 1, 9, 0, 0, 0, 0, 65536}, 1, '{55, 1}},
        // zero and negative height step
        '{'{0, 0, 99, 5, 5, 65536, 65536, 65536, 0, 0, 100, 100}, 1, '{99, 1}},
        '{'{1, 0, 42, 5, 5, 65536, 65536, 65536, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000},
          1, '{42, 1}},
        // still air and zero level weight
        '{'{0, 0, 321, 0, 0, 65536, 65536, 65536, 65536, 65536, 0, 65536},
          1, '{321, 0}},
        '{'{1, 1, 654, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1, 1, 0, 0, 0, 1},
          1, '{654, 0}},
        // predicted rows
        '{'{0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1, 1, 0, 0, 0, 1}, 0, '{0, 0}},
        '{'{1, 0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1, 1, 65536, 0, 0, 1},
          0, '{0, 0}},
        '{'{0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
            31'h7FFF_FFFF, 131071, 131071, 32'h8000_0000, 32'h7FFF_FFFF}, 0, '{0, 0}},
        '{'{0, 0, 1000, 65536 * 10, 65536 * 3, 65536, 65536, 65536, 0, 0, 0, 65536 * 20},
          0, '{0, 0}},
        '{'{1, 0, 1000, -65536 * 10, -65536 * 3, 65536, 65536, 65536, 32768, 32768,
            0, 65536 * 20}, 0, '{0, 0}},
        '{'{0, 0, 0, -65536 * 50, 65536 * 5, 80000, 60000, 70000, 65536, 65536,
            -65536, 65536}, 0, '{0, 0}},
        '{'{1, 0, 0, 65536 * 200, 65536 * 300, 65536, 65536, 65536, 0, 131071, 0, 1},
          0, '{0, 0}}
    };

    // output side: ready pattern and checking
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready = ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_tend want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (tend_q.size() == 0) begin
                $display("%0t: unexpected beat rhs_out %h fault %b", $time, o_rhs_out,
                         o_fault);
                err_count++;
            end else begin
                want = tend_q.pop_front();
                if (o_rhs_out !== want.rhs) begin
                    $display("%0t: rhs_out expected %h actual %h", $time, want.rhs,
                             o_rhs_out);
                    err_count++;
                end
                if (o_fault !== want.fault) begin
                    $display("%0t: fault expected %b actual %b", $time, want.fault,
                             o_fault);
                    err_count++;
                end
            end
        end
    end

    // run limit
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // stimulus
    initial begin
        bit [20:0] setting[5][3];
        int        total;
        int        drain;
        setting = '{'{1, 1049, 10486}, '{0, 0, 21'h1F_FFFF}, '{255, 1048576, 1048576},
                    '{8, 21'h1F_FFFF, 0}, '{0, 0, 0}};
        err_count = 0;
        tx_idle_pct = 36;
        rx_idle_pct = 70;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = bsdt_pkg::REG_DRAG_LEVELS;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_mode = 1'b0;
        i_level = '0;
        i_rhs_in = '0;
        i_mom_x = '0;
        i_mom_y = '0;
        i_rho_here = '0;
        i_rho_west = '0;
        i_rho_south = '0;
        i_mask_here = '0;
        i_mask_neighbor = '0;
        i_z_bottom = '0;
        i_z_top = '0;
        levels_reg = bsdt_pkg::DRAG_LEVELS_RST;
        sea_reg = bsdt_pkg::SEA_COEFF_RST;
        land_reg = bsdt_pkg::LAND_COEFF_RST;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) send_point(dir_rows[i].p, dir_rows[i].typed, dir_rows[i].res);
        i_in_valid = 1'b0;

        // random phases, one drag setting each
        total = 0;
        for (int ph = 0; ph < 6; ph++) begin
            wait (tend_q.size() == 0);
            @(negedge i_clk);
            if (ph < 5) begin
                write_reg(bsdt_pkg::REG_DRAG_LEVELS, setting[ph][0]);
                write_reg(bsdt_pkg::REG_SEA_COEFF, setting[ph][1]);
                write_reg(bsdt_pkg::REG_LAND_COEFF, setting[ph][2]);
            end else begin
                write_reg(bsdt_pkg::REG_DRAG_LEVELS, 21'($urandom_range(1, 255)));
                write_reg(bsdt_pkg::REG_SEA_COEFF, 21'($urandom_range(0, 2097151)));
                write_reg(bsdt_pkg::REG_LAND_COEFF, 21'($urandom_range(0, 2097151)));
            end
            for (int n = 0; n < 205; n++) begin
                case (total * 3 / 1230)
                    0: begin tx_idle_pct = 36; rx_idle_pct = 70; end
                    1: begin tx_idle_pct = 70; rx_idle_pct = 36; end
                    default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
                endcase
                send_point(rand_point(), 1'b0, '{0, 0});
                total++;
            end
            i_in_valid = 1'b0;
        end

        // drain, then a short quiet window for stray beats
        drain = 0;
        while (tend_q.size() != 0 && drain < 100000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (300) @(posedge i_clk);
        if (err_count == 0 && tend_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
